>>> rtl/itp_pkg.sv
package itp_pkg;

    // ascii characters the converter recognizes
    localparam logic [7:0] CHAR_LPAR  = 8'h28;  // (
    localparam logic [7:0] CHAR_RPAR  = 8'h29;  // )
    localparam logic [7:0] CHAR_STAR  = 8'h2A;  // *
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // +
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // -
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // /
    localparam logic [7:0] CHAR_CARET = 8'h5E;  // ^
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // operator stack entry codes
    localparam logic [2:0] CODE_LPAR  = 3'd0;
    localparam logic [2:0] CODE_PLUS  = 3'd1;
    localparam logic [2:0] CODE_MINUS = 3'd2;
    localparam logic [2:0] CODE_STAR  = 3'd3;
    localparam logic [2:0] CODE_SLASH = 3'd4;
    localparam logic [2:0] CODE_CARET = 3'd5;
    localparam logic [2:0] CODE_NONE  = 3'd7;

    // error codes on the result channel
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_PAREN    = 2'd2;
    localparam logic [1:0] ERR_INVALID  = 2'd3;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        K_ALNUM,
        K_OPER,
        K_RPAR,
        K_INVALID,
        K_END
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] code;
        logic [7:0] sym;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_EVAL,
        ST_PUSH,
        ST_FINAL
    } back_state_t;

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] r;
        r = CODE_NONE;
        unique case (c)
            CHAR_LPAR:  r = CODE_LPAR;
            CHAR_PLUS:  r = CODE_PLUS;
            CHAR_MINUS: r = CODE_MINUS;
            CHAR_STAR:  r = CODE_STAR;
            CHAR_SLASH: r = CODE_SLASH;
            CHAR_CARET: r = CODE_CARET;
            default:    r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
               (c >= CHAR_LA && c <= CHAR_LZ);
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] r;
        r = CHAR_NUL;
        unique case (code)
            CODE_LPAR:  r = CHAR_LPAR;
            CODE_PLUS:  r = CHAR_PLUS;
            CODE_MINUS: r = CHAR_MINUS;
            CODE_STAR:  r = CHAR_STAR;
            CODE_SLASH: r = CHAR_SLASH;
            CODE_CARET: r = CHAR_CARET;
            default:    r = CHAR_NUL;
        endcase
        return r;
    endfunction

    // in-stack priority
    function automatic logic [2:0] isp(input logic [2:0] code);
        logic [2:0] r;
        r = 3'd0;
        unique case (code)
            CODE_PLUS, CODE_MINUS: r = 3'd1;
            CODE_STAR, CODE_SLASH: r = 3'd2;
            CODE_CARET:            r = 3'd3;
            default:               r = 3'd0;
        endcase
        return r;
    endfunction

    // incoming priority
    function automatic logic [2:0] icp(input logic [2:0] code);
        logic [2:0] r;
        r = 3'd0;
        unique case (code)
            CODE_LPAR, CODE_CARET: r = 3'd4;
            CODE_PLUS, CODE_MINUS: r = 3'd1;
            CODE_STAR, CODE_SLASH: r = 3'd2;
            default:               r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/itp_front.sv
module itp_front (
    input  logic           command,
    input  logic [7:0]     symbol,
    output itp_pkg::item_t item
);
    import itp_pkg::*;

    logic [2:0] code;

    assign code = op_code(symbol);

    // classify the incoming character
    always_comb
    begin
        item.sym  = symbol;
        item.code = code;
        if (command)
        begin
            item.kind = K_END;
        end
        else if (is_alnum(symbol))
        begin
            item.kind = K_ALNUM;
        end
        else if (symbol == CHAR_RPAR)
        begin
            item.kind = K_RPAR;
        end
        else if (code != CODE_NONE)
        begin
            item.kind = K_OPER;
        end
        else
        begin
            item.kind = K_INVALID;
        end
    end

endmodule

>>> rtl/itp_queue.sv
module itp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  itp_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output itp_pkg::item_t pop_item
);
    import itp_pkg::*;

    localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != QCW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/itp_back.sv
module itp_back #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_pop,
    input  itp_pkg::item_t q_item,
    output logic           result_valid,
    input  logic           result_ready,
    output logic [7:0]     out_symbol,
    output logic           is_end,
    output logic [1:0]     error
);
    import itp_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    back_state_t    state_reg, state_next;
    item_t          cmd_reg, cmd_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [1:0]     err_reg, err_next;
    logic [2:0]     stack_mem_reg [STACK_DEPTH];
    logic [2:0]     rd_data_reg;
    logic [CW-1:0]  cnt_m1;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           mem_we;
    logic           stack_empty;
    logic           stack_full;
    logic           last_entry;
    logic           out_free;
    logic [7:0]     top_char;
    logic           emit;
    logic [7:0]     emit_sym;
    logic           emit_end;
    logic [1:0]     emit_err;
    logic           result_valid_reg;
    logic [7:0]     out_symbol_reg;
    logic           is_end_reg;
    logic [1:0]     error_reg;

    assign cnt_m1      = count_reg - CW'(1);
    assign rd_addr     = cnt_m1[AW-1:0];
    assign wr_addr     = count_reg[AW-1:0];
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg >= CW'(STACK_DEPTH));
    assign last_entry  = (cnt_m1 == '0);
    assign out_free    = !result_valid_reg || result_ready;
    assign top_char    = code_char(rd_data_reg);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        err_next   = err_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        emit       = 1'b0;
        emit_sym   = cmd_reg.sym;
        emit_end   = 1'b0;
        emit_err   = ERR_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_item;
                    q_pop      = 1'b1;
                    err_next   = ERR_NONE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (cmd_reg.kind)
                    K_ALNUM:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    K_INVALID:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_err   = ERR_INVALID;
                            state_next = ST_IDLE;
                        end
                    end
                    K_OPER:
                    begin
                        state_next = stack_empty ? ST_PUSH : ST_READ;
                    end
                    K_RPAR, K_END:
                    begin
                        state_next = stack_empty ? ST_FINAL : ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                unique case (cmd_reg.kind)
                    K_OPER:
                    begin
                        if (isp(rd_data_reg) < icp(cmd_reg.code))
                        begin
                            state_next = ST_PUSH;
                        end
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_sym   = top_char;
                            count_next = cnt_m1;
                            state_next = last_entry ? ST_PUSH : ST_READ;
                        end
                    end
                    K_RPAR:
                    begin
                        if (rd_data_reg == CODE_LPAR)
                        begin
                            count_next = cnt_m1;
                            state_next = ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_sym   = top_char;
                            count_next = cnt_m1;
                            state_next = last_entry ? ST_FINAL : ST_READ;
                        end
                    end
                    K_END:
                    begin
                        if (rd_data_reg == CODE_LPAR)
                        begin
                            err_next   = ERR_PAREN;
                            count_next = cnt_m1;
                            state_next = last_entry ? ST_FINAL : ST_READ;
                        end
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_sym   = top_char;
                            count_next = cnt_m1;
                            state_next = last_entry ? ST_FINAL : ST_READ;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_PUSH:
            begin
                if (stack_full)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_err   = ERR_OVERFLOW;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (cmd_reg.kind == K_END)
                    begin
                        emit_sym = CHAR_NUL;
                        emit_end = 1'b1;
                        emit_err = err_reg;
                    end
                    else
                    begin
                        emit_err = ERR_PAREN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        err_reg <= err_next;
        if (emit)
        begin
            out_symbol_reg <= emit_sym;
            is_end_reg     <= emit_end;
            error_reg      <= emit_err;
        end
    end

    // operator stack, registered read of the top entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem_reg[wr_addr] <= cmd_reg.code;
        end
        rd_data_reg <= stack_mem_reg[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign out_symbol   = out_symbol_reg;
    assign is_end       = is_end_reg;
    assign error        = error_reg;

endmodule

>>> rtl/infix_to_postfix_converter.sv
// infix to postfix converter: a letter, digit or invalid character passes through the queue
// entry, the back end's command register and the result register before its result is valid;
// with no output stall the back end walks IDLE and DISPATCH for each transaction, then READ
// and EVAL for each stack entry it reads (each pop and the entry that stops an operator), then
// PUSH or FINAL where needed; it handles one transaction at a time, and READ waits on the registered stack read
// reset (rst_n low, asynchronous) empties the stack, the queue and the result register
module infix_to_postfix_converter #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    // input transaction: one infix character or an end command
    input  logic       item_valid,
    output logic       item_ready,
    input  logic       command,
    input  logic [7:0] symbol,
    // result transaction: one postfix character, an error or the end marker
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_symbol,
    output logic       is_end,
    output logic [1:0] error
);
    import itp_pkg::*;

    item_t front_item;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    // front: classify the character into letter/digit, operator, ')', invalid or end,
    // and look up the operator code once so the back end never decodes ascii
    itp_front u_front (
        .command (command),
        .symbol  (symbol),
        .item    (front_item)
    );

    // short queue so the input side keeps taking transactions while the back end
    // is busy popping the stack
    itp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_ready (item_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    // back: shunting-yard sequencer with the operator stack and the result register;
    // the stack bottom acts as an implicit '('
    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_symbol   (out_symbol),
        .is_end       (is_end),
        .error        (error)
    );

endmodule
